@@ rtl/core/dequ_pkg.sv @@
// dequ_pkg: shared types and constants for the double-ended queue unit
// request, status and controller state encodings; no dependencies
`default_nettype none

package dequ_pkg;

	localparam int DATA_W    = 32;
	localparam int DEPTH_DEF = 64;
	localparam int INDEX_W   = 6;
	localparam int SIZE_W    = 7;

	typedef enum logic [2:0] {
		REQ_PUSH_TAIL = 3'd0,
		REQ_PUSH_HEAD = 3'd1,
		REQ_POP_HEAD  = 3'd2,
		REQ_POP_TAIL  = 3'd3,
		REQ_RESIZE    = 3'd4,
		REQ_READ      = 3'd5,
		REQ_WRITE     = 3'd6,
		REQ_DUMP      = 3'd7
	} req_type_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GROW,
		S_GROW_DONE,
		S_RD_OUT,
		S_DUMP_RD
	} state_t;

endpackage

`default_nettype wire

@@ rtl/core/dequ_ram.sv @@
// dequ_ram: generic single-write, single-read synchronous ram
// read data registered; no package dependency
`default_nettype none

module dequ_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/double_ended_queue_unit.sv @@
// double_ended_queue_unit: circular-buffer deque of signed words with random access
// depends on dequ_pkg and dequ_ram
//
// usage: one request item enters on in_valid/in_stall (req_type, index, value,
// new_size); result items leave on out_valid/out_stall (data_out, status, last).
// an item is accepted only while the controller is idle and the output register
// is empty or being drained in the same cycle.
// steps per item, from acceptance until the next request can be accepted:
//   push, pop, write, shrinking resize, error cases, empty dump: done at acceptance
//   read: one synchronous ram read, then the output register loads
//   growing resize: one zero write per cycle for each added slot
//   non-empty dump: per element, a ram read, then a load into the output register
// the single ram port pair sets this sequencing.
// results appear in the output register the cycle after the deciding edge and
// hold while out_stall is high; a stalled output holds off new requests once
// the controller needs the register again.
// reset clears the front slot, the element count, the controller and the
// output valid; the ram contents are not cleared and every live slot is
// written before it is read.
`default_nettype none

module double_ended_queue_unit import dequ_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [2:0]               req_type,
	input  wire logic [INDEX_W-1:0]       index,
	input  wire logic signed [DATA_W-1:0] value,
	input  wire logic [SIZE_W-1:0]        new_size,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [DATA_W-1:0]      data_out,
	output logic [1:0]                    status,
	output logic                          last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t state_q, state_d;

	logic [AW-1:0] front_q, front_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] target_q, target_d;
	logic [CW-1:0] pos_q, pos_d;

	logic                     out_valid_q;
	logic signed [DATA_W-1:0] data_out_q;
	status_t                  status_q;
	logic                     last_q;

	logic                     out_load;
	logic signed [DATA_W-1:0] res_data;
	status_t                  res_status;
	logic                     res_last;

	logic              ram_we, ram_re;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	logic      out_free, accept, full, empty, idx_bad, dump_last;
	req_type_t req;

	// physical slot of position pos counted from the front
	function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] front,
			input logic [CW-1:0] pos);
		logic [AW:0] s;
		s = {1'b0, front} + (AW+1)'(pos);
		if (s >= (AW+1)'(DEPTH)) begin
			s = s - (AW+1)'(DEPTH);
		end
		return s[AW-1:0];
	endfunction

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = !(state_q == S_IDLE && out_free);
	assign accept    = in_valid && !in_stall;
	assign req       = req_type_t'(req_type);
	assign full      = count_q == CW'(DEPTH);
	assign empty     = count_q == '0;
	assign idx_bad   = {1'b0, index} >= SIZE_W'(count_q);
	assign dump_last = (pos_q + CW'(1)) == count_q;

	dequ_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (req == REQ_READ && !idx_bad) begin
						state_d = S_RD_OUT;
					end else if (req == REQ_DUMP && !empty) begin
						state_d = S_RD_OUT;
					end else if (req == REQ_RESIZE && new_size <= SIZE_W'(DEPTH)
							&& new_size > SIZE_W'(count_q)) begin
						state_d = S_GROW;
					end
				end
			end
			S_GROW: begin
				if ((count_q + CW'(1)) == target_q) begin
					state_d = S_GROW_DONE;
				end
			end
			S_GROW_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			S_RD_OUT: begin
				if (target_q == '0 || dump_last) begin
					state_d = S_IDLE;
				end else begin
					state_d = S_DUMP_RD;
				end
			end
			S_DUMP_RD: begin
				if (out_free) begin
					state_d = S_RD_OUT;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// datapath and memory control
	// target_q doubles as the dump flag in S_RD_OUT: zero means a single read
	always_comb begin
		front_d    = front_q;
		count_d    = count_q;
		target_d   = target_q;
		pos_d      = pos_q;
		ram_we     = 1'b0;
		ram_waddr  = slot_of(front_q, count_q);
		ram_wdata  = value;
		ram_re     = 1'b0;
		ram_raddr  = slot_of(front_q, pos_q);
		out_load   = 1'b0;
		res_data   = '0;
		res_status = STAT_OK;
		res_last   = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req)
						REQ_PUSH_TAIL: begin
							out_load = 1'b1;
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								ram_we  = 1'b1;
								count_d = count_q + CW'(1);
							end
						end
						REQ_PUSH_HEAD: begin
							out_load = 1'b1;
							if (full) begin
								res_status = STAT_FULL;
							end else begin
								front_d   = (front_q == '0) ? AW'(DEPTH - 1)
									: front_q - AW'(1);
								ram_we    = 1'b1;
								ram_waddr = front_d;
								count_d   = count_q + CW'(1);
							end
						end
						REQ_POP_HEAD: begin
							out_load = 1'b1;
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								front_d = (front_q == AW'(DEPTH - 1)) ? '0
									: front_q + AW'(1);
								count_d = count_q - CW'(1);
							end
						end
						REQ_POP_TAIL: begin
							out_load = 1'b1;
							if (empty) begin
								res_status = STAT_EMPTY;
							end else begin
								count_d = count_q - CW'(1);
							end
						end
						REQ_RESIZE: begin
							if (new_size > SIZE_W'(DEPTH)) begin
								out_load   = 1'b1;
								res_status = STAT_FULL;
							end else if (new_size > SIZE_W'(count_q)) begin
								target_d = CW'(new_size);
							end else begin
								out_load = 1'b1;
								count_d  = CW'(new_size);
							end
						end
						REQ_READ: begin
							if (idx_bad) begin
								out_load   = 1'b1;
								res_status = STAT_RANGE;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = slot_of(front_q, CW'(index));
								target_d  = '0;
							end
						end
						REQ_WRITE: begin
							out_load = 1'b1;
							if (idx_bad) begin
								res_status = STAT_RANGE;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = slot_of(front_q, CW'(index));
							end
						end
						REQ_DUMP: begin
							if (empty) begin
								out_load   = 1'b1;
								res_status = STAT_EMPTY;
							end else begin
								ram_re    = 1'b1;
								ram_raddr = front_q;
								pos_d     = '0;
								target_d  = count_q;
							end
						end
						default: ;
					endcase
				end
			end
			S_GROW: begin
				// one zero slot appended per cycle
				ram_we    = 1'b1;
				ram_wdata = '0;
				count_d   = count_q + CW'(1);
			end
			S_GROW_DONE: begin
				out_load = out_free;
			end
			S_RD_OUT: begin
				// output register is empty here: the read was issued with it free
				out_load = 1'b1;
				res_data = ram_rdata;
				if (target_q != '0) begin
					res_last = dump_last;
					pos_d    = pos_q + CW'(1);
				end
			end
			S_DUMP_RD: begin
				ram_re = out_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			front_q     <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			front_q <= front_d;
			count_q <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		target_q <= target_d;
		pos_q    <= pos_d;
		if (out_load) begin
			data_out_q <= res_data;
			status_q   <= res_status;
			last_q     <= res_last;
		end
	end

	assign out_valid = out_valid_q;
	assign data_out  = data_out_q;
	assign status    = status_q;
	assign last      = last_q;

endmodule

`default_nettype wire
